/* sv/otrb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// otrb_pkg
// Types and constants for the overwriting trace ring buffer.
// ----------------------------------------------------------------------------
package otrb_pkg;

  localparam int Depth = 1024;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = PtrW + 1;
  localparam int LevelLsb = 24;
  localparam int LevelBits = 4;
  localparam int QDepth = 2;

  localparam logic [1:0] CMD_LOG = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_LOGGED = 3'd0;
  localparam logic [2:0] ST_CAT_DROP = 3'd1;
  localparam logic [2:0] ST_LVL_DROP = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  localparam logic CFG_CATEGORY_MASK = 1'b0;
  localparam logic CFG_MIN_LEVEL = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [31:0] category;
    logic [31:0] tag;
    logic signed [31:0] extra_a;
    logic signed [31:0] extra_b;
    logic [63:0] timestamp;
    logic [31:0] want_sequence;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] got_sequence;
    logic [63:0] got_timestamp;
    logic [31:0] got_category;
    logic [31:0] got_tag;
    logic signed [31:0] got_extra_a;
    logic signed [31:0] got_extra_b;
    logic [31:0] overtaken_count;
    logic [10:0] remaining_count;
    logic [31:0] total_count;
  } out_item_t;

  typedef struct packed {
    logic [63:0] timestamp;
    logic [31:0] category;
    logic [31:0] tag;
    logic [31:0] extra_a;
    logic [31:0] extra_b;
    logic [31:0] seq;
  } entry_t;

  // classified operation from front to back
  typedef struct packed {
    logic [2:0] status;
    logic wr;
    logic rd;
    logic [PtrW-1:0] slot;
    entry_t entry;
    logic [31:0] lost;
    logic [CntW-1:0] remain;
    logic [31:0] total;
  } op_t;

endpackage

`default_nettype wire

/* sv/overwriting_trace_ring_buffer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer
// Path: an accepted beat is registered in the store access stage, then
// written into the result queue, which drives the outputs.
// Flow: full rises when the two-entry result queue plus the beat in flight
// reach two; a new beat can be accepted while one is still in flight.
// Reset: synchronous; clears pointers, counters and the minimum level, sets
// the category mask to all ones; store, queue and data registers untouched.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_idx,
  input wire logic [31:0] cfg_data,
  input wire logic push,
  output logic full,
  input wire otrb_pkg::in_item_t in_item,
  output logic empty,
  input wire logic pop,
  output otrb_pkg::out_item_t out_item
);
  import otrb_pkg::*;

  op_t op;
  logic acc;

  assign acc = push && !full;

  otrb_front u_front (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid(acc), .in_item, .op
  );

  otrb_back u_back (
    .clk, .rst, .op_valid(acc), .op, .busy(full),
    .empty, .pop, .res(out_item)
  );

endmodule

`default_nettype wire

/* sv/otrb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// otrb_front
// Filters items, keeps pointers and counters, issues store operations.
// ----------------------------------------------------------------------------
module otrb_front (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic cfg_idx,
  input wire logic [31:0] cfg_data,
  input wire logic in_valid,
  input wire otrb_pkg::in_item_t in_item,
  output otrb_pkg::op_t op
);
  import otrb_pkg::*;

  logic [31:0] category_mask;
  logic [3:0] min_level;
  logic [PtrW-1:0] head_ptr, tail_ptr;
  logic [CntW-1:0] held_count;
  logic [31:0] logged_total, lost_total;

  logic [LevelBits-1:0] level;
  logic [31:0] base, d;
  logic full;

  always_comb begin
    level = in_item.tag[LevelLsb +: LevelBits];
    full = held_count >= CntW'(Depth);
    base = logged_total - 32'(held_count);
    d = in_item.want_sequence - base;
    if (d[31]) d = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      category_mask <= '1;
      min_level <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_CATEGORY_MASK) category_mask <= cfg_data;
      else min_level <= cfg_data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      held_count <= '0;
      logged_total <= '0;
      lost_total <= '0;
    end else if (in_valid) begin
      case (in_item.cmd)
        CMD_LOG: begin
          if ((in_item.category & category_mask) != 0 &&
              !(min_level != 0 && 8'(level) < 8'(min_level))) begin
            if (full) begin
              tail_ptr <= (tail_ptr == PtrW'(Depth - 1)) ? '0 : tail_ptr + 1'b1;
              lost_total <= lost_total + 1;
            end else begin
              held_count <= held_count + 1'b1;
            end
            head_ptr <= (head_ptr == PtrW'(Depth - 1)) ? '0 : head_ptr + 1'b1;
            logged_total <= logged_total + 1;
          end
        end
        CMD_CLEAR: begin
          head_ptr <= '0;
          tail_ptr <= '0;
          held_count <= '0;
          logged_total <= '0;
          lost_total <= '0;
        end
        default: ;
      endcase
    end
  end

  logic [CntW:0] sum;
  always_comb begin
    op = '0;
    sum = '0;
    op.lost = lost_total;
    op.total = logged_total;
    op.status = ST_NONE;
    case (in_item.cmd)
      CMD_LOG: begin
        if ((in_item.category & category_mask) == 0) begin
          op.status = ST_CAT_DROP;
        end else if (min_level != 0 && 8'(level) < 8'(min_level)) begin
          op.status = ST_LVL_DROP;
        end else begin
          op.status = ST_LOGGED;
          op.wr = 1'b1;
          op.slot = head_ptr;
          op.entry.timestamp = in_item.timestamp;
          op.entry.category = in_item.category;
          op.entry.tag = in_item.tag;
          op.entry.extra_a = in_item.extra_a;
          op.entry.extra_b = in_item.extra_b;
          op.entry.seq = logged_total;
          op.total = logged_total + 1;
          op.lost = full ? lost_total + 1 : lost_total;
        end
      end
      CMD_READ: begin
        if (d < 32'(held_count)) begin
          op.status = ST_READ;
          op.rd = 1'b1;
          sum = (CntW + 1)'(tail_ptr) + (CntW + 1)'(d[CntW-1:0]);
          if (sum >= (CntW + 1)'(Depth)) sum = sum - (CntW + 1)'(Depth);
          op.slot = sum[PtrW-1:0];
          op.remain = held_count - d[CntW-1:0] - 1'b1;
        end
      end
      CMD_CLEAR: begin
        op.status = ST_CLEARED;
        op.lost = '0;
        op.total = '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/otrb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// otrb_back
// Store memory and result queue; memory reads are registered.
// ----------------------------------------------------------------------------
module otrb_back (
  input wire logic clk,
  input wire logic rst,
  input wire logic op_valid,
  input wire otrb_pkg::op_t op,
  output logic busy,
  output logic empty,
  input wire logic pop,
  output otrb_pkg::out_item_t res
);
  import otrb_pkg::*;

  entry_t mem [Depth];
  entry_t rd_data;
  op_t pend;
  logic pend_valid;
  out_item_t q [QDepth];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  out_item_t nres;
  logic push_q, pop_q;

  always_ff @(posedge clk) begin
    if (op_valid && op.wr) mem[op.slot] <= op.entry;
    rd_data <= mem[op.slot];
  end

  always_ff @(posedge clk) begin
    pend <= op;
    if (rst) pend_valid <= 1'b0;
    else pend_valid <= op_valid;
  end

  always_comb begin
    nres = '0;
    nres.status = pend.status;
    nres.overtaken_count = pend.lost;
    nres.total_count = pend.total;
    nres.remaining_count = 11'(pend.remain);
    if (pend.wr || pend.rd) begin
      nres.got_sequence = pend.rd ? rd_data.seq : pend.entry.seq;
      nres.got_timestamp = pend.rd ? rd_data.timestamp : pend.entry.timestamp;
      nres.got_category = pend.rd ? rd_data.category : pend.entry.category;
      nres.got_tag = pend.rd ? rd_data.tag : pend.entry.tag;
      nres.got_extra_a = pend.rd ? rd_data.extra_a : pend.entry.extra_a;
      nres.got_extra_b = pend.rd ? rd_data.extra_b : pend.entry.extra_b;
    end
  end

  assign push_q = pend_valid;
  assign empty = (cnt == 2'd0);
  assign pop_q = pop && !empty;
  assign res = q[rd_ptr];
  // one in flight plus queue must fit
  assign busy = (32'(cnt) + 32'(pend_valid)) >= QDepth;

  always_ff @(posedge clk) begin
    if (push_q) q[wr_ptr] <= nres;
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push_q) wr_ptr <= ~wr_ptr;
      if (pop_q) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push_q) - 2'(pop_q);
    end
  end

endmodule

`default_nettype wire

/* bench/overwriting_trace_ring_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_trace_ring_buffer_tb
// Drives log, read, clear and unknown commands through the trace ring with
// random bursts and pop stalls, predicts every result beat from a local
// model of the ring and counters, and compares field by field.
// ----------------------------------------------------------------------------
module overwriting_trace_ring_buffer_tb;
  import otrb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_CATEGORY_MASK;
  logic [31:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;

  overwriting_trace_ring_buffer DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .push(push), .full(full), .in_item(in_item), .empty(empty), .pop(pop),
    .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // trace ring mirror
  entry_t ring [Depth];
  logic [PtrW-1:0] head, tail;
  logic [CntW-1:0] held;
  logic [31:0] logged, lost;
  logic [31:0] mask_mirror;
  logic [3:0] lvl_min;

  in_item_t pending_items[$];
  out_item_t expected_beats[$];
  int errors = 0;
  int hold_off = 0;
  int burst = 0, gap = 0;
  bit feeding = 1'b0;

  function automatic out_item_t trace_step(in_item_t it);
    out_item_t r;
    logic [31:0] base, d;
    logic [PtrW:0] s;
    logic [3:0] lvl;
    r = '0;
    lvl = it.tag[LevelLsb +: LevelBits];
    case (it.cmd)
      CMD_LOG: begin
        if ((it.category & mask_mirror) == 0) r.status = ST_CAT_DROP;
        else if (lvl_min != 0 && lvl < lvl_min) r.status = ST_LVL_DROP;
        else begin
          if (held >= Depth) begin
            tail = tail + 1'b1;
            held = held - 1'b1;
            lost = lost + 1;
          end
          ring[head] = '{it.timestamp, it.category, it.tag, it.extra_a, it.extra_b,
                         logged};
          r.got_sequence = logged;
          r.got_timestamp = it.timestamp;
          r.got_category = it.category;
          r.got_tag = it.tag;
          r.got_extra_a = it.extra_a;
          r.got_extra_b = it.extra_b;
          head = head + 1'b1;
          held = held + 1'b1;
          logged = logged + 1;
          r.status = ST_LOGGED;
        end
      end
      CMD_READ: begin
        base = logged - 32'(held);
        d = it.want_sequence - base;
        if (d[31]) d = 0;
        if (d < 32'(held)) begin
          s = {1'b0, tail} + d[PtrW:0];
          r.got_sequence = ring[s[PtrW-1:0]].seq;
          r.got_timestamp = ring[s[PtrW-1:0]].timestamp;
          r.got_category = ring[s[PtrW-1:0]].category;
          r.got_tag = ring[s[PtrW-1:0]].tag;
          r.got_extra_a = ring[s[PtrW-1:0]].extra_a;
          r.got_extra_b = ring[s[PtrW-1:0]].extra_b;
          r.remaining_count = 11'(32'(held) - d - 1);
          r.status = ST_READ;
        end else r.status = ST_NONE;
      end
      CMD_CLEAR: begin
        logged = 0; lost = 0; held = 0; head = 0; tail = 0;
        r.status = ST_CLEARED;
      end
      default: r.status = ST_NONE;
    endcase
    r.overtaken_count = lost;
    r.total_count = logged;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (status %0d)", what, got, want,
             out_item.status);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) expected_beats.push_back(trace_step(in_item));
      if (!(push && full)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          push <= 1'b0;
        end else if (feeding && pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          push <= 1'b1;
          if (burst <= 1) begin
            burst <= $urandom_range(1, 20);
            gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end else burst <= burst - 1;
        end else push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("unexpected result beat, status %0d", out_item.status);
        end else begin
          out_item_t e;
          e = expected_beats.pop_front();
          if (out_item.status !== e.status) report("status", out_item.status, e.status);
          if (out_item.got_sequence !== e.got_sequence)
            report("sequence", out_item.got_sequence, e.got_sequence);
          if (out_item.got_timestamp !== e.got_timestamp)
            report("timestamp", out_item.got_timestamp, e.got_timestamp);
          if (out_item.got_category !== e.got_category)
            report("category", out_item.got_category, e.got_category);
          if (out_item.got_tag !== e.got_tag) report("tag", out_item.got_tag, e.got_tag);
          if (out_item.got_extra_a !== e.got_extra_a)
            report("extra_a", out_item.got_extra_a, e.got_extra_a);
          if (out_item.got_extra_b !== e.got_extra_b)
            report("extra_b", out_item.got_extra_b, e.got_extra_b);
          if (out_item.overtaken_count !== e.overtaken_count)
            report("overtaken", out_item.overtaken_count, e.overtaken_count);
          if (out_item.remaining_count !== e.remaining_count)
            report("remaining", out_item.remaining_count, e.remaining_count);
          if (out_item.total_count !== e.total_count)
            report("total", out_item.total_count, e.total_count);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else pop <= ($urandom_range(0, 3) != 0) || (($urandom_range(0, 15) == 0) ? 1'b0 : 1'b1);
    end
  end

  function automatic in_item_t rand_item(logic [1:0] cmd);
    in_item_t it;
    it.cmd = cmd;
    it.category = $urandom();
    if ($urandom_range(0, 3) == 0) it.category = 32'(1) << $urandom_range(0, 31);
    it.tag = $urandom();
    it.extra_a = $urandom();
    it.extra_b = $urandom();
    it.timestamp = {$urandom(), $urandom()};
    it.want_sequence = $urandom();
    return it;
  endfunction

  function automatic in_item_t read_item(logic [31:0] want);
    in_item_t it;
    it = rand_item(CMD_READ);
    it.want_sequence = want;
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CATEGORY_MASK) mask_mirror = val;
    else lvl_min = val[3:0];
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    while (pending_items.size() > 0 || push || expected_beats.size() > 0) @(posedge clk);
    feeding = 1'b0;
    repeat (6) @(posedge clk);
  endtask

  task automatic random_items(int n, int lo_seq_span);
    in_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) it = rand_item(CMD_LOG);
      else if (r < 90) begin
        it = read_item(logged + pending_items.size() - $urandom_range(0, lo_seq_span));
        if ($urandom_range(0, 4) == 0) it.want_sequence = $urandom();
      end else if (r < 93) it = rand_item(CMD_CLEAR);
      else if (r < 96) it = rand_item(CMD_UNUSED);
      else it = read_item($urandom_range(0, 40));
      pending_items.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    head = 0; tail = 0; held = 0; logged = 0; lost = 0;
    mask_mirror = 32'hFFFF_FFFF; lvl_min = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, unknown cmd, extremes, clamp, drops, clear
    pending_items.push_back(read_item(0));
    pending_items.push_back(rand_item(CMD_UNUSED));
    it = rand_item(CMD_LOG);
    it.category = '1; it.tag = '1; it.extra_a = 32'h8000_0000; it.extra_b = 32'h7FFF_FFFF;
    it.timestamp = '1;
    pending_items.push_back(it);
    it.category = 32'h1; it.tag = '0; it.extra_a = '0; it.extra_b = '1; it.timestamp = '0;
    pending_items.push_back(it);
    pending_items.push_back(read_item(32'hFFFF_FFFF));
    pending_items.push_back(read_item(1));
    pending_items.push_back(read_item(2));
    pending_items.push_back(read_item(32'h8000_0000));
    pending_items.push_back(rand_item(CMD_CLEAR));
    pending_items.push_back(read_item(0));
    run_phase();
    write_reg(CFG_CATEGORY_MASK, 32'h0000_00F0);
    write_reg(CFG_MIN_LEVEL, 4'd15);
    it = rand_item(CMD_LOG); it.category = 32'h0F; pending_items.push_back(it);
    it.category = 32'h10; it.tag[27:24] = 4'd14; pending_items.push_back(it);
    it.tag[27:24] = 4'd15; pending_items.push_back(it);
    it.category = 32'h80; it.tag[27:24] = 4'd0; pending_items.push_back(it);
    pending_items.push_back(read_item(0));
    run_phase();

    // fill past the ring depth with a long pop hold-off to back up the input
    write_reg(CFG_CATEGORY_MASK, 32'hFFFF_FFFF);
    write_reg(CFG_MIN_LEVEL, 4'd0);
    hold_off = 300;
    for (int i = 0; i < 1100; i++) pending_items.push_back(rand_item(CMD_LOG));
    pending_items.push_back(read_item(0));
    pending_items.push_back(read_item(76));
    pending_items.push_back(read_item(1099));
    pending_items.push_back(read_item(1100));
    run_phase();

    // random phases over several register settings
    random_items(70, 30);
    run_phase();
    write_reg(CFG_CATEGORY_MASK, $urandom());
    write_reg(CFG_MIN_LEVEL, $urandom_range(1, 15));
    random_items(60, 30);
    run_phase();
    write_reg(CFG_CATEGORY_MASK, 32'h0000_0001);
    write_reg(CFG_MIN_LEVEL, 4'd1);
    random_items(50, 30);
    run_phase();

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
